// ===== hw/rtl/first_fit_extent_allocator_defines.svh =====
// Assertion macros for the first-fit extent allocator.
// Used by every RTL file that checks properties; relies on clk and arst_n in scope.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define FFA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FFA_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define FFA_ASSERT(label, prop, msg)
`define FFA_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== hw/rtl/ffa_pkg.sv =====
// Shared types and constants for the first-fit extent allocator.
// No dependencies; used by ffa_table and first_fit_extent_allocator.
package ffa_pkg;

	localparam int TableEntries = 1024;
	localparam int IdxW = $clog2(TableEntries);
	localparam int CntW = IdxW + 1;
	localparam int StartW = 32;
	localparam int LenW = 24;
	localparam int BaseW = 16;
	localparam int ThrW = 10;
	localparam int CurW = StartW + 1;
	localparam int EndW = StartW + 2;
	localparam logic [CntW-1:0] SlotsMax = CntW'(TableEntries);

	localparam logic ReqAlloc = 1'b0;
	localparam logic ReqFree = 1'b1;

	localparam logic [1:0] StatusOk = 2'd0;
	localparam logic [1:0] StatusNotFound = 2'd1;
	localparam logic [1:0] StatusFull = 2'd2;
	localparam logic [1:0] StatusPastLimit = 2'd3;

	localparam logic [1:0] CfgBaseOffset = 2'd0;
	localparam logic [1:0] CfgCompactThreshold = 2'd1;
	localparam logic [1:0] CfgSpaceLimit = 2'd2;

	typedef struct packed {
		logic req_type;
		logic [LenW-1:0] alloc_length;
		logic [StartW-1:0] free_position;
	} req_t;

	typedef struct packed {
		logic [StartW-1:0] position;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic valid;
		logic [StartW-1:0] start;
		logic [LenW-1:0] length;
	} entry_t;

	typedef struct packed {
		logic rd_en;
		logic [IdxW-1:0] rd_addr;
		logic wr_en;
		logic [IdxW-1:0] wr_addr;
		entry_t wr_data;
	} tbl_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC_SCAN,
		ST_ALLOC_DEC,
		ST_SHIFT,
		ST_PLACE,
		ST_FREE_SCAN,
		ST_COMPACT,
		ST_FINISH
	} state_t;

endpackage

// ===== hw/rtl/first_fit_extent_allocator.sv =====
// Top level of the first-fit extent allocator: sequencer, scan unit and registers.
// Depends on ffa_pkg, ffa_table and first_fit_extent_allocator_defines.svh.
//
// Channel   Handshake              Word
// req       req_valid / req_stall  ffa_pkg::req_t  (req_type, alloc_length, free_position)
// rsp       rsp_valid / rsp_stall  ffa_pkg::rsp_t  (position, status)
// cfg       cfg_valid / cfg_ready  cfg_index (2 bits), cfg_data (32 bits)
//
// One request at a time; the table memory reads and writes one slot per cycle.
// Scan: reads the slots in order until one ends the search or it runs off the end.
// Allocate: scan, decide, shift the slots at and above the insert slot up by one on insert,
// then place and finish. Free: scan, compact when needed, then finish.
// Reset empties the table with no sweep.
// A stalled result waits in the output register while the next request is taken.
`include "first_fit_extent_allocator_defines.svh"

module first_fit_extent_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ffa_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ffa_pkg::rsp_t  rsp_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_data
);

	ffa_pkg::state_t state_q, state_d;
	ffa_pkg::tbl_ctrl_t ctrl;
	ffa_pkg::entry_t ent;

	logic [ffa_pkg::BaseW-1:0] base_offset_q;
	logic [ffa_pkg::ThrW-1:0] compact_threshold_q;
	logic [ffa_pkg::StartW-1:0] space_limit_q;

	logic [ffa_pkg::CntW-1:0] n_q;
	logic [ffa_pkg::CntW-1:0] rd_idx_q;
	logic [ffa_pkg::CntW-1:0] ev_idx_q;
	logic [ffa_pkg::CntW-1:0] slot_q;
	logic [ffa_pkg::CntW-1:0] passed_q;
	logic [ffa_pkg::CntW-1:0] cnt_q;
	logic pend_q;
	logic grow_q;
	logic out_valid_q;
	ffa_pkg::req_t req_q;
	ffa_pkg::rsp_t rsp_q;
	logic [ffa_pkg::CurW-1:0] cursor_q;
	logic [ffa_pkg::EndW-1:0] endp_q;
	logic [ffa_pkg::StartW-1:0] res_pos_q;
	logic [1:0] res_status_q;

	logic [ffa_pkg::CntW-1:0] ev_next;
	logic [ffa_pkg::CntW-1:0] wr_slot;
	logic [ffa_pkg::CurW-1:0] sum_se;
	logic [ffa_pkg::EndW-1:0] sum_end;
	logic [ffa_pkg::EndW-1:0] init_end;
	logic more;
	logic scan_done;
	logic a_hit;
	logic f_hit;
	logic f_compact;
	logic over_limit;
	logic full;
	logic out_free;

	ffa_table u_table (
		.clk     (clk),
		.ctrl    (ctrl),
		.rd_data (ent)
	);

	assign ev_next = ev_idx_q + 1'b1;
	assign wr_slot = {1'b0, ctrl.wr_addr};
	assign sum_se = {1'b0, ent.start} + {{(ffa_pkg::CurW - ffa_pkg::LenW){1'b0}}, ent.length};
	assign sum_end = {1'b0, sum_se} + {{(ffa_pkg::EndW - ffa_pkg::LenW){1'b0}}, req_q.alloc_length};
	assign init_end = {{(ffa_pkg::EndW - ffa_pkg::BaseW){1'b0}}, base_offset_q}
		+ {{(ffa_pkg::EndW - ffa_pkg::LenW){1'b0}}, req_data.alloc_length};
	assign more = rd_idx_q < n_q;
	assign scan_done = !pend_q && !more;
	assign a_hit = pend_q && ent.valid && ({2'b0, ent.start} >= endp_q);
	assign f_hit = pend_q && ent.valid && (ent.start == req_q.free_position);
	assign f_compact = (passed_q > {1'b0, compact_threshold_q}) || (ev_idx_q == '0);
	assign over_limit = endp_q > {2'b0, space_limit_q};
	assign full = n_q == ffa_pkg::SlotsMax;
	assign out_free = !out_valid_q || !rsp_stall;

	assign req_stall = state_q != ffa_pkg::ST_IDLE;
	assign rsp_valid = out_valid_q;
	assign rsp_data = rsp_q;
	assign cfg_ready = 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffa_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = (req_data.req_type == ffa_pkg::ReqAlloc) ? ffa_pkg::ST_ALLOC_SCAN
						: ffa_pkg::ST_FREE_SCAN;
				end
			end
			ffa_pkg::ST_ALLOC_SCAN: begin
				if (a_hit || scan_done) begin
					state_d = ffa_pkg::ST_ALLOC_DEC;
				end
			end
			ffa_pkg::ST_ALLOC_DEC: begin
				if (over_limit || (grow_q && full)) begin
					state_d = ffa_pkg::ST_FINISH;
				end else if (grow_q && (slot_q < n_q)) begin
					state_d = ffa_pkg::ST_SHIFT;
				end else begin
					state_d = ffa_pkg::ST_PLACE;
				end
			end
			ffa_pkg::ST_SHIFT: begin
				if ((cnt_q == '0) && !pend_q) begin
					state_d = ffa_pkg::ST_PLACE;
				end
			end
			ffa_pkg::ST_PLACE: state_d = ffa_pkg::ST_FINISH;
			ffa_pkg::ST_FREE_SCAN: begin
				if (f_hit) begin
					state_d = f_compact ? ffa_pkg::ST_COMPACT : ffa_pkg::ST_FINISH;
				end else if (scan_done) begin
					state_d = ffa_pkg::ST_FINISH;
				end
			end
			ffa_pkg::ST_COMPACT: begin
				if (scan_done) begin
					state_d = ffa_pkg::ST_FINISH;
				end
			end
			ffa_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = ffa_pkg::ST_IDLE;
				end
			end
			default: state_d = ffa_pkg::ST_IDLE;
		endcase
	end

	// table port control
	always_comb begin
		ctrl.rd_en = 1'b0;
		ctrl.rd_addr = rd_idx_q[ffa_pkg::IdxW-1:0];
		ctrl.wr_en = 1'b0;
		ctrl.wr_addr = ev_idx_q[ffa_pkg::IdxW-1:0];
		ctrl.wr_data = ent;
		case (state_q)
			ffa_pkg::ST_ALLOC_SCAN: ctrl.rd_en = more && !a_hit;
			ffa_pkg::ST_SHIFT: begin
				ctrl.rd_en = cnt_q != '0;
				ctrl.wr_en = pend_q;
				ctrl.wr_addr = ev_next[ffa_pkg::IdxW-1:0];
			end
			ffa_pkg::ST_PLACE: begin
				ctrl.wr_en = 1'b1;
				ctrl.wr_addr = slot_q[ffa_pkg::IdxW-1:0];
				ctrl.wr_data.valid = 1'b1;
				ctrl.wr_data.start = cursor_q[ffa_pkg::StartW-1:0];
				ctrl.wr_data.length = req_q.alloc_length;
			end
			ffa_pkg::ST_FREE_SCAN: begin
				ctrl.rd_en = more && !f_hit;
				ctrl.wr_en = f_hit;
				ctrl.wr_data.valid = 1'b0;
			end
			ffa_pkg::ST_COMPACT: begin
				ctrl.rd_en = more;
				ctrl.wr_en = pend_q && ent.valid;
				ctrl.wr_addr = slot_q[ffa_pkg::IdxW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffa_pkg::ST_IDLE;
			n_q <= '0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
			base_offset_q <= 16'd4;
			compact_threshold_q <= 10'd500;
			space_limit_q <= 32'hFFFF_FFFF;
		end else begin
			state_q <= state_d;
			pend_q <= ctrl.rd_en;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ffa_pkg::CfgBaseOffset: base_offset_q <= cfg_data[ffa_pkg::BaseW-1:0];
					ffa_pkg::CfgCompactThreshold:
						compact_threshold_q <= cfg_data[ffa_pkg::ThrW-1:0];
					ffa_pkg::CfgSpaceLimit: space_limit_q <= cfg_data;
					default: ;
				endcase
			end
			if ((state_q == ffa_pkg::ST_PLACE) && grow_q) begin
				n_q <= n_q + 1'b1;
			end
			if ((state_q == ffa_pkg::ST_COMPACT) && scan_done) begin
				n_q <= slot_q;
			end
			if ((state_q == ffa_pkg::ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			ev_idx_q <= rd_idx_q;
		end
		case (state_q)
			ffa_pkg::ST_IDLE: begin
				req_q <= req_data;
				rd_idx_q <= '0;
				slot_q <= '0;
				passed_q <= '0;
				cursor_q <= {{(ffa_pkg::CurW - ffa_pkg::BaseW){1'b0}}, base_offset_q};
				endp_q <= init_end;
			end
			ffa_pkg::ST_ALLOC_SCAN: begin
				if (ctrl.rd_en) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (pend_q && ent.valid && !a_hit) begin
					cursor_q <= sum_se;
					endp_q <= sum_end;
					slot_q <= ev_next;
				end
				if (a_hit) begin
					grow_q <= slot_q == ev_idx_q;
				end else if (scan_done) begin
					grow_q <= slot_q >= n_q;
				end
			end
			ffa_pkg::ST_ALLOC_DEC: begin
				res_pos_q <= '0;
				res_status_q <= over_limit ? ffa_pkg::StatusPastLimit : ffa_pkg::StatusFull;
				rd_idx_q <= n_q - 1'b1;
				cnt_q <= n_q - slot_q;
			end
			ffa_pkg::ST_SHIFT: begin
				if (ctrl.rd_en) begin
					rd_idx_q <= rd_idx_q - 1'b1;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ffa_pkg::ST_PLACE: begin
				res_pos_q <= cursor_q[ffa_pkg::StartW-1:0];
				res_status_q <= ffa_pkg::StatusOk;
			end
			ffa_pkg::ST_FREE_SCAN: begin
				res_pos_q <= '0;
				if (ctrl.rd_en) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (pend_q && !ent.valid) begin
					passed_q <= passed_q + 1'b1;
				end
				if (f_hit) begin
					res_status_q <= ffa_pkg::StatusOk;
					rd_idx_q <= '0;
					slot_q <= '0;
				end else begin
					res_status_q <= ffa_pkg::StatusNotFound;
				end
			end
			ffa_pkg::ST_COMPACT: begin
				if (ctrl.rd_en) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (pend_q && ent.valid) begin
					slot_q <= slot_q + 1'b1;
				end
			end
			ffa_pkg::ST_FINISH: begin
				if (out_free) begin
					rsp_q.position <= res_pos_q;
					rsp_q.status <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	`FFA_ASSERT(a_slots_bound, n_q <= ffa_pkg::SlotsMax, "slot count past table size")
	`FFA_ASSERT(a_shift_above_slot, (state_q == ffa_pkg::ST_SHIFT) && ctrl.wr_en |-> wr_slot > slot_q, "shift wrote at or below insert slot")
	`FFA_ASSERT(a_compact_order, (state_q == ffa_pkg::ST_COMPACT) && ctrl.wr_en |-> wr_slot <= ev_idx_q, "compaction overtook its read index")
	`FFA_ASSERT(a_free_clears, (state_q == ffa_pkg::ST_FREE_SCAN) && ctrl.wr_en |-> !ctrl.wr_data.valid, "free wrote a live slot")
	`FFA_ASSERT(a_fail_pos_zero, out_valid_q && (rsp_q.status != ffa_pkg::StatusOk) |-> rsp_q.position == '0, "failed request carries a position")
	`FFA_ASSERT(a_word_from_finish, $rose(out_valid_q) |-> $past(state_q == ffa_pkg::ST_FINISH), "result word raised outside finish")

endmodule

// ===== hw/rtl/ffa_table.sv =====
// Extent table memory: one write port, one registered read port.
// Depends on ffa_pkg for the entry and port control types.
module ffa_table (
	input  logic               clk,
	input  ffa_pkg::tbl_ctrl_t ctrl,
	output ffa_pkg::entry_t    rd_data
);

	ffa_pkg::entry_t mem [ffa_pkg::TableEntries];

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_addr] <= ctrl.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_data <= mem[ctrl.rd_addr];
		end
	end

endmodule

// ===== sim/first_fit_extent_allocator_tb.sv =====
`timescale 1ns / 100ps
// Testbench for first_fit_extent_allocator: directed script, random phases, closing edge cases.
// Depends on ffa_pkg and the RTL; results are checked against an in-bench extent table.

module first_fit_extent_allocator_tb;
	import ffa_pkg::*;

	localparam int GapMax = 40;
	localparam int WatchdogLimit = 8 * (2 * TableEntries + 5 + 2 * GapMax);
	localparam int DrainCycles = 2 * TableEntries + 8;
	localparam int Phases = 8;
	localparam int PhaseItems = 70;
	localparam logic [1:0] CfgUnused = 2'd3;

	typedef struct packed {
		bit reg_write;
		logic [1:0] reg_idx;
		logic [31:0] reg_val;
		req_t word;
		bit typed;
		rsp_t want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	logic [StartW-1:0] tbl_start [TableEntries];
	logic [LenW-1:0] tbl_len [TableEntries];
	bit tbl_live [TableEntries];
	int unsigned tbl_used;
	logic [BaseW-1:0] base_reg;
	logic [ThrW-1:0] thr_reg;
	logic [31:0] limit_reg;

	rsp_t awaited [$];
	step_t script [$];
	int fails = 0;
	bit calm = 1'b0;
	int hold_cnt = 0;
	int idle_cycles = 0;

	first_fit_extent_allocator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, GapMax);
	endfunction

	function automatic void compact_table();
		int unsigned dst;
		dst = 0;
		for (int unsigned src = 0; src < tbl_used; src++)
			if (tbl_live[src]) begin
				tbl_start[dst] = tbl_start[src];
				tbl_len[dst] = tbl_len[src];
				tbl_live[dst] = 1'b1;
				dst++;
			end
		for (int unsigned src = dst; src < tbl_used; src++)
			tbl_live[src] = 1'b0;
		tbl_used = dst;
	endfunction

	function automatic rsp_t place_extent(logic [LenW-1:0] len);
		longint unsigned cursor;
		int unsigned slot;
		bit stop;
		bit grow;
		rsp_t r;
		cursor = 64'(base_reg);
		slot = 0;
		stop = 1'b0;
		r = '0;
		for (int unsigned i = 0; i < tbl_used && !stop; i++)
			if (tbl_live[i]) begin
				if (longint'(tbl_start[i]) >= cursor + len)
					stop = 1'b1;
				else begin
					cursor = longint'(tbl_start[i]) + tbl_len[i];
					slot = i + 1;
				end
			end
		if (cursor + len > longint'(limit_reg)) begin
			r.status = StatusPastLimit;
			return r;
		end
		grow = (slot >= tbl_used) || tbl_live[slot];
		if (grow && tbl_used >= TableEntries) begin
			r.status = StatusFull;
			return r;
		end
		if (grow) begin
			for (int unsigned i = tbl_used; i > slot; i--) begin
				tbl_start[i] = tbl_start[i-1];
				tbl_len[i] = tbl_len[i-1];
				tbl_live[i] = tbl_live[i-1];
			end
			tbl_used++;
		end
		tbl_start[slot] = StartW'(cursor);
		tbl_len[slot] = len;
		tbl_live[slot] = 1'b1;
		r.position = StartW'(cursor);
		r.status = StatusOk;
		return r;
	endfunction

	function automatic rsp_t free_extent(logic [StartW-1:0] pos);
		int unsigned passed;
		rsp_t r;
		passed = 0;
		r = '0;
		r.status = StatusNotFound;
		for (int unsigned i = 0; i < tbl_used; i++) begin
			if (!tbl_live[i])
				passed++;
			else if (tbl_start[i] == pos) begin
				tbl_live[i] = 1'b0;
				if (passed > thr_reg || i == 0)
					compact_table();
				r.status = StatusOk;
				return r;
			end
		end
		return r;
	endfunction

	function automatic rsp_t model_word(req_t w);
		if (w.req_type == ReqAlloc)
			return place_extent(w.alloc_length);
		return free_extent(w.free_position);
	endfunction

	function automatic bit pick_live(output logic [StartW-1:0] pos);
		int unsigned i0;
		int unsigned i;
		pos = '0;
		if (tbl_used == 0)
			return 1'b0;
		i0 = $urandom_range(0, tbl_used - 1);
		for (int unsigned j = 0; j < tbl_used; j++) begin
			i = (i0 + j) % tbl_used;
			if (tbl_live[i]) begin
				pos = tbl_start[i];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic req_t random_word();
		req_t w;
		int r;
		int k;
		logic [StartW-1:0] pos;
		w.req_type = ReqFree;
		w.alloc_length = LenW'($urandom);
		w.free_position = $urandom;
		r = $urandom_range(0, 99);
		if (r < ((tbl_used > 120) ? 30 : 60)) begin
			w.req_type = ReqAlloc;
			k = $urandom_range(0, 9);
			if (k < 6)
				w.alloc_length = LenW'($urandom_range(0, 64));
			else if (k < 8)
				w.alloc_length = LenW'($urandom_range(0, 4096));
			else if (k < 9)
				w.alloc_length = LenW'($urandom);
			else
				w.alloc_length = '1;
		end else if (r < 92) begin
			if (pick_live(pos))
				w.free_position = pos;
		end
		return w;
	endfunction

	function automatic step_t alloc_step(logic [LenW-1:0] len, bit typed = 1'b0,
			logic [StartW-1:0] at = '0, logic [1:0] st = StatusOk);
		step_t s;
		s = '0;
		s.word.req_type = ReqAlloc;
		s.word.alloc_length = len;
		s.typed = typed;
		s.want.position = at;
		s.want.status = st;
		return s;
	endfunction

	function automatic step_t free_step(logic [StartW-1:0] pos, bit typed = 1'b0,
			logic [1:0] st = StatusOk);
		step_t s;
		s = '0;
		s.word.req_type = ReqFree;
		s.word.free_position = pos;
		s.typed = typed;
		s.want.status = st;
		return s;
	endfunction

	function automatic step_t reg_step(logic [1:0] idx, logic [31:0] val);
		step_t s;
		s = '0;
		s.reg_write = 1'b1;
		s.reg_idx = idx;
		s.reg_val = val;
		return s;
	endfunction

	task automatic park_requests();
		if (req_valid)
			req_valid <= 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		park_requests();
		while (awaited.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CfgBaseOffset: base_reg = val[BaseW-1:0];
			CfgCompactThreshold: thr_reg = val[ThrW-1:0];
			CfgSpaceLimit: limit_reg = val;
			default: ;
		endcase
	endtask

	task automatic send_word(input req_t w, input bit typed = 1'b0, input rsp_t want = '0);
		rsp_t got;
		int gap;
		if (cfg_valid)
			cfg_valid <= 1'b0;
		req_valid <= 1'b1;
		req_data <= w;
		do
			@(posedge clk);
		while (req_stall);
		got = model_word(w);
		awaited.push_back(typed ? want : got);
		gap = calm ? 0 : gap_len();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
			hold_cnt <= calm ? 0 : gap_len();
		end
	end

	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited.size() == 0) begin
				$error("unexpected word: position %0h status %0d",
					rsp_data.position, rsp_data.status);
				fails++;
			end else begin
				want = awaited.pop_front();
				if (rsp_data.position !== want.position) begin
					$error("position: expected %0h, got %0h", want.position, rsp_data.position);
					fails++;
				end
				if (rsp_data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_data.status);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WatchdogLimit) begin
			$display("Test completed with failures");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		step_t s;
		logic [StartW-1:0] pos;
		logic [BaseW-1:0] b;
		logic [31:0] val;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tbl_used = 0;
		base_reg = 16'd4;
		thr_reg = 10'd500;
		limit_reg = '1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		script.push_back(free_step(32'h0, 1'b1, StatusNotFound));
		script.push_back(alloc_step(24'd0, 1'b1, 32'd4));
		script.push_back(alloc_step(24'd16));
		script.push_back(alloc_step(24'hFF_FFFF));
		script.push_back(alloc_step(24'd1));
		script.push_back(free_step(32'd20, 1'b1));
		script.push_back(alloc_step(24'd8));
		script.push_back(free_step(32'd4, 1'b1));
		script.push_back(free_step(32'hFFFF_FFFF, 1'b1, StatusNotFound));
		script.push_back(reg_step(CfgSpaceLimit, 32'h0));
		script.push_back(alloc_step(24'd1, 1'b1, 32'h0, StatusPastLimit));
		script.push_back(alloc_step(24'd0, 1'b1, 32'h0, StatusPastLimit));
		script.push_back(reg_step(CfgBaseOffset, 32'h0));
		script.push_back(alloc_step(24'd0, 1'b1, 32'h0));
		script.push_back(free_step(32'h0, 1'b1));
		script.push_back(reg_step(CfgSpaceLimit, 32'hFFFF_FFFF));
		script.push_back(reg_step(CfgBaseOffset, 32'hFFFF_FFFF));
		script.push_back(reg_step(CfgCompactThreshold, 32'h0));
		script.push_back(reg_step(CfgUnused, 32'h1234_5678));
		script.push_back(alloc_step(24'hFF_FFFF));
		script.push_back(alloc_step(24'hFF_FFFF));
		script.push_back(free_step(32'd20, 1'b1));
		script.push_back(free_step(32'h0100_0013, 1'b1));
		script.push_back(reg_step(CfgCompactThreshold, 32'hFFFF_FFFF));
		foreach (script[i]) begin
			if (script[i].reg_write)
				write_reg(script[i].reg_idx, script[i].reg_val);
			else
				send_word(script[i].word, script[i].typed, script[i].want);
		end

		for (int p = 0; p < Phases; p++) begin
			calm = (p % 4 == 3);
			case ($urandom_range(0, 3))
				0: b = '0;
				1: b = '1;
				2: b = 16'd4;
				default: b = BaseW'($urandom);
			endcase
			write_reg(CfgBaseOffset, {16'($urandom), b});
			case ($urandom_range(0, 3))
				0: val = 32'd0;
				1: val = 32'd1023;
				2: val = $urandom_range(1, 4);
				default: val = $urandom;
			endcase
			write_reg(CfgCompactThreshold, val);
			case ($urandom_range(0, 5))
				0, 1: val = '1;
				2: val = 32'(b) + $urandom_range(0, 200000);
				3: val = $urandom;
				4: val = 32'd0;
				default: val = 32'(b) + $urandom_range(0, 5000);
			endcase
			write_reg(CfgSpaceLimit, val);
			if ($urandom_range(0, 3) == 0)
				write_reg(CfgUnused, $urandom);
			repeat (PhaseItems) send_word(random_word());
		end

		// close with a limit miss, a free at compaction threshold zero and an offset-zero free
		calm = 1'b0;
		write_reg(CfgBaseOffset, 32'h0);
		write_reg(CfgSpaceLimit, 32'h0);
		s = alloc_step(24'd1, 1'b1, 32'h0, StatusPastLimit);
		send_word(s.word, s.typed, s.want);
		write_reg(CfgSpaceLimit, 32'hFFFF_FFFF);
		write_reg(CfgCompactThreshold, 32'h0);
		if (pick_live(pos)) begin
			s = free_step(pos);
			send_word(s.word);
		end
		s = free_step(32'h0);
		send_word(s.word);
		s = alloc_step(LenW'($urandom_range(1, 64)));
		send_word(s.word);

		park_requests();
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_table.sv
hw/rtl/first_fit_extent_allocator.sv
sim/first_fit_extent_allocator_tb.sv
